FILE: rtl/tsc_pkg.sv
// tsc_pkg: shared types and fixed constants of the tilt servo controller
// no dependencies; imported by the controller and its servo value unit
`default_nettype none

package tsc_pkg;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_TARGET = 3'd0,
    REG_ACTIVE = 3'd1,
    REG_DIR    = 3'd2,
    REG_CENTER = 3'd3,
    REG_SWING  = 3'd4,
    REG_LIMIT  = 3'd5,
    REG_GAIN   = 3'd6
  } cfg_reg_t;

  localparam int ANGLE_W   = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;
  localparam int CNT_W     = 3;
  localparam int INT_W     = 16;
  localparam int MH_W      = 14;   // |pct*swing| >> frac bits, at most 100*127
  localparam int QF_W      = 7;
  localparam int QI_W      = 8;
  localparam int K_W       = 11;

  localparam int PCT_GAIN    = 6;
  localparam int GAIN_MIN    = 35;
  localparam int INT_BIAS    = 12800;  // lifts the integral above zero before /100
  localparam int RECIP_MUL   = 5243;   // ceil(2^19 / 100), exact below 43690
  localparam int RECIP_SHIFT = 19;

  // per-item values handed to the emit stage
  typedef struct packed {
    logic signed [QI_W-1:0] qi;      // floor(integral / 100)
    logic [QF_W-1:0]        qf;      // floor(|pct*swing| / den)
    logic [MH_W-1:0]        mh;      // |pct*swing| >> frac bits
    logic                   mlo_nz;  // fraction bits dropped by that shift were nonzero
    logic                   p_neg;   // pct*swing is negative
  } item_t;

endpackage

`default_nettype wire

FILE: rtl/tsc_servo_calc.sv
// tsc_servo_calc: one servo command from the per-item values and its direction bit
// depends on tsc_pkg
`default_nettype none

module tsc_servo_calc (
  input  tsc_pkg::item_t item,
  input  logic           neg,
  input  logic [7:0]     center,
  input  logic [6:0]     swing,
  output logic [7:0]     angle
);
  import tsc_pkg::*;

  logic                  rf_nz;
  logic signed [K_W-1:0] u;
  logic signed [K_W-1:0] qi_x;
  logic signed [K_W-1:0] c_x;
  logic signed [K_W-1:0] k;
  logic signed [K_W-1:0] v;
  logic                  t_pos;
  logic [8:0]            lo;
  logic [8:0]            hi_sum;
  logic [8:0]            hi;
  logic signed [K_W-1:0] lo_s;
  logic signed [K_W-1:0] hi_s;
  logic signed [K_W-1:0] res;

  // remainder of |p| / den is nonzero
  assign rf_nz = item.mlo_nz | (item.mh != (MH_W'(item.qf) * MH_W'(100)));

  assign u    = item.p_neg ? -K_W'(item.qf) : K_W'(item.qf);
  assign qi_x = K_W'(item.qi);
  assign c_x  = K_W'(center);
  assign k    = neg ? (c_x - qi_x - u) : (c_x + qi_x + u);

  // sign of the leftover fraction relative to k
  assign t_pos = neg ? item.p_neg : !item.p_neg;

  // truncate toward zero: value lies strictly between k and k+-1
  always_comb begin
    v = k;
    if (rf_nz) begin
      if (t_pos && k < 0) begin
        v = k + K_W'(1);
      end else if (!t_pos && k > 0) begin
        v = k - K_W'(1);
      end
    end
  end

  assign lo     = (center >= {1'b0, swing}) ? 9'(center - {1'b0, swing}) : 9'd0;
  assign hi_sum = 9'(center) + 9'(swing);
  assign hi     = (hi_sum > 9'd255) ? 9'd255 : hi_sum;
  assign lo_s   = K_W'(lo);
  assign hi_s   = K_W'(hi);

  always_comb begin
    res = v;
    if (res < lo_s) begin
      res = lo_s;
    end
    if (res > hi_s) begin
      res = hi_s;
    end
  end

  assign angle = res[7:0];

endmodule

`default_nettype wire

FILE: rtl/tilt_servo_controller.sv
// tilt_servo_controller: tilt error to per-servo position commands with integral trim
// depends on tsc_pkg and tsc_servo_calc
// first command of an item passes the input, quotient and emit stage registers and the output register
// throughput, while out_tready is high: one item per cycle when at most one servo is
//   active, else one servo command per cycle, set by the emit stage that forms one per cycle
// reset (synchronous, rst_n low): pipeline empty, integral zero, registers at defaults
`default_nettype none

module tilt_servo_controller #(
  parameter int MAX_SERVOS      = 4,
  parameter int ANGLE_FRAC_BITS = 7
) (
  input  logic        clk,
  input  logic        rst_n,
  // input items
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] measured_angle
  input  logic        in_tuser,   // [0] clear_integral
  // servo commands
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [1:0] servo_index, [9:2] servo_angle, [15:10] zero
  output logic        out_tlast,  // last command of the item
  // register writes
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [tsc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tsc_pkg::CFG_DAT_W-1:0]  cfg_data
);
  import tsc_pkg::*;

  localparam int F      = ANGLE_FRAC_BITS;
  localparam int DEN    = 100 << F;
  localparam int PCT_W  = (F + 9 > 20) ? F + 9 : 20;
  localparam int PROD_W = PCT_W + 8;
  localparam logic signed [PCT_W-1:0] DEN_S = PCT_W'(DEN);

  // ---------------------------------------------------------------- config
  logic signed [15:0] target_r;
  logic [2:0]         active_r;
  logic [3:0]         dir_r;
  logic [7:0]         center_r;
  logic [6:0]         swing_r;
  logic [6:0]         limit_r;
  logic [7:0]         gain_r;
  logic               gain_clr;

  assign cfg_ready = 1'b1;
  // a gain below the minimum disables the integral and flushes it
  assign gain_clr  = cfg_valid && (cfg_reg_t'(cfg_index) == REG_GAIN)
                     && (cfg_data[7:0] < 8'(GAIN_MIN));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= '0;
      active_r <= 3'd4;
      dir_r    <= '0;
      center_r <= 8'd90;
      swing_r  <= 7'd45;
      limit_r  <= 7'd10;
      gain_r   <= '0;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_TARGET: target_r <= cfg_data;
        REG_ACTIVE: active_r <= cfg_data[2:0];
        REG_DIR:    dir_r    <= cfg_data[3:0];
        REG_CENTER: center_r <= cfg_data[7:0];
        REG_SWING:  swing_r  <= cfg_data[6:0];
        REG_LIMIT:  limit_r  <= cfg_data[6:0];
        REG_GAIN:   gain_r   <= gain_clr ? 8'd0 : cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- flow control
  logic       s0_valid_r, s1_valid_r, s2_valid_r, out_valid_r;
  logic       s0_ready, s1_ready, s2_ready, out_take;
  logic       s0_adv, s2_done, emit;
  logic [2:0] n_eff;
  logic       last_servo;
  logic [CNT_W-1:0] cnt_r;

  // servos per item, capped at the build size
  assign n_eff = (int'(active_r) > MAX_SERVOS) ? 3'(MAX_SERVOS) : active_r;

  assign out_take   = !out_valid_r || out_tready;
  assign last_servo = (cnt_r == 3'(n_eff - 3'd1));
  assign emit       = s2_valid_r && (n_eff != 3'd0) && out_take;
  // an item with no active servo leaves the emit stage at once
  assign s2_done    = s2_valid_r && ((n_eff == 3'd0) || (emit && last_servo));
  assign s2_ready   = !s2_valid_r || s2_done;
  assign s1_ready   = !s1_valid_r || s2_ready;
  assign s0_ready   = !s0_valid_r || s1_ready;
  assign s0_adv     = s0_valid_r && s1_ready;
  assign in_tready  = s0_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r  <= 1'b0;
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      if (s0_ready) begin
        s0_valid_r <= in_tvalid;
      end
      if (s1_ready) begin
        s1_valid_r <= s0_valid_r;
      end
      if (s2_ready) begin
        s2_valid_r <= s1_valid_r;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
        cnt_r       <= last_servo ? '0 : cnt_r + CNT_W'(1);
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- stage 0: input register
  logic signed [15:0] s0_meas_r;
  logic               s0_clr_r;

  always_ff @(posedge clk) begin
    if (s0_ready) begin
      s0_meas_r <= in_tdata;
      s0_clr_r  <= in_tuser;
    end
  end

  // tilt error and percentage, clamped to +-100 percent (den)
  logic signed [16:0]       delta;
  logic                     d_pos, d_neg;
  logic signed [PCT_W-1:0]  pct_raw, pct;
  logic signed [PROD_W-1:0] prod;
  logic [PROD_W-1:0]        mag;

  assign delta   = 17'(target_r) - 17'(s0_meas_r);
  assign d_neg   = delta[16];
  assign d_pos   = !delta[16] && (delta != '0);
  assign pct_raw = PCT_W'(delta) * PCT_W'(PCT_GAIN);

  always_comb begin
    pct = pct_raw;
    if (pct_raw >= DEN_S) begin
      pct = DEN_S;
    end else if (pct_raw <= -DEN_S) begin
      pct = -DEN_S;
    end
  end

  assign prod = PROD_W'(pct) * PROD_W'($signed({1'b0, swing_r}));
  assign mag  = prod[PROD_W-1] ? PROD_W'(-prod) : PROD_W'(prod);

  // integral: cleared by the item flag, quotient by 100 through a biased reciprocal
  logic signed [INT_W-1:0] integral_r, integral_nxt, integ_eff;
  logic signed [16:0]      ybias;
  logic [27:0]             qy;
  logic signed [8:0]       qi9;
  logic signed [16:0]      step, isum, bound;

  assign integ_eff = s0_clr_r ? '0 : integral_r;
  assign ybias     = 17'(integ_eff) + 17'(INT_BIAS);
  assign qy        = 28'(ybias[14:0]) * 28'(RECIP_MUL);
  assign qi9       = $signed(qy[RECIP_SHIFT +: 9]) - 9'sd128;

  // integral moves by the gain toward the sign of the error, inside +-limit*100
  assign step  = d_pos ? 17'(gain_r) : (d_neg ? -17'(gain_r) : '0);
  assign isum  = 17'(integ_eff) + step;
  assign bound = 17'(14'(limit_r) * 14'd100);

  always_comb begin
    integral_nxt = INT_W'(isum);
    if (isum > bound) begin
      integral_nxt = INT_W'(bound);
    end else if (isum < -bound) begin
      integral_nxt = INT_W'(-bound);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integral_r <= '0;
    end else if (gain_clr) begin
      integral_r <= '0;
    end else if (s0_adv) begin
      integral_r <= integral_nxt;
    end
  end

  // ---------------------------------------------------------------- stage 1: quotient by den
  logic signed [QI_W-1:0] s1_qi_r;
  logic [MH_W-1:0]        s1_mh_r;
  logic                   s1_mlo_nz_r;
  logic                   s1_pneg_r;
  logic [26:0]            qf_prod;
  item_t                  s1_item;

  always_ff @(posedge clk) begin
    if (s1_ready) begin
      s1_qi_r     <= QI_W'(qi9);
      s1_mh_r     <= mag[F +: MH_W];
      s1_mlo_nz_r <= |mag[F-1:0];
      s1_pneg_r   <= prod[PROD_W-1];
    end
  end

  assign qf_prod = 27'(s1_mh_r) * 27'(RECIP_MUL);

  always_comb begin
    s1_item.qi     = s1_qi_r;
    s1_item.qf     = qf_prod[RECIP_SHIFT +: QF_W];
    s1_item.mh     = s1_mh_r;
    s1_item.mlo_nz = s1_mlo_nz_r;
    s1_item.p_neg  = s1_pneg_r;
  end

  // ---------------------------------------------------------------- stage 2: one servo a cycle
  item_t      s2_item_r;
  logic       servo_neg;
  logic [7:0] servo_angle;

  always_ff @(posedge clk) begin
    if (s2_ready) begin
      s2_item_r <= s1_item;
    end
  end

  // direction bits exist for the first four servos only
  assign servo_neg = (cnt_r < CNT_W'(4)) && dir_r[cnt_r[1:0]];

  tsc_servo_calc u_calc (
    .item   (s2_item_r),
    .neg    (servo_neg),
    .center (center_r),
    .swing  (swing_r),
    .angle  (servo_angle)
  );

  // ---------------------------------------------------------------- output register
  logic [15:0] out_tdata_r;
  logic        out_tlast_r;

  always_ff @(posedge clk) begin
    if (emit) begin
      out_tdata_r <= {6'd0, servo_angle, cnt_r[1:0]};
      out_tlast_r <= last_servo;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;

endmodule

`default_nettype wire

FILE: rtl/tsc_checker.sv
// tsc_checker: port-level checks of the tilt servo controller, bound to the top level
// depends on tilt_servo_controller for the bind
`default_nettype none

module tsc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic        out_tlast
);

  logic       out_acc;
  logic [1:0] exp_idx_r;

  assign out_acc = out_tvalid && out_tready;

  // servo index expected on the next command: zero after a last command
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_idx_r <= '0;
    end else if (out_acc) begin
      exp_idx_r <= out_tlast ? 2'd0 : 2'(out_tdata[1:0] + 2'd1);
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("servo command changed while stalled");

  a_idx_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc |-> out_tdata[1:0] == exp_idx_r)
    else $error("servo commands out of order");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[15:10] == 6'd0)
    else $error("padding bits of command not zero");

  a_no_out_from_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> !out_tvalid)
    else $error("command present right after reset");

endmodule

bind tilt_servo_controller tsc_checker u_tsc_checker (.*);

`default_nettype wire
